>>> sv/rau_pkg.sv
// Rational arithmetic unit: shared constants, operation and status codes.
// No dependencies; used by the top level and the testbench.
package rau_pkg;

    // Operand width default and fixed field widths
    localparam int VALUE_BITS_DEF = 32;
    localparam int FIELD_BITS     = 32;
    localparam int DEN_BITS       = 31;
    localparam int IN_DATA_BITS   = 136;
    localparam int OUT_DATA_BITS  = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

endpackage

>>> sv/rau_mul.sv
// Registered unsigned multiplier shared by all cross products.
// No package dependencies.
module rau_mul #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    output logic [2*WIDTH-1:0] o_prod
);

    logic [2*WIDTH-1:0] r_prod;

    // One product per cycle, result in the cycle after its operands
    always_ff @(posedge i_clk) begin
        r_prod <= (2*WIDTH)'(i_a) * (2*WIDTH)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> sv/rau_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// No package dependencies; used for the exact division by the gcd.
module rau_div #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH:0]   r_rem;
    logic [WIDTH-1:0] r_quot;
    logic [WIDTH-1:0] r_div;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   rem_sh;
    logic             fits;

    // Shift in the next dividend bit and try the subtraction
    assign rem_sh = {r_rem[WIDTH-1:0], r_quot[WIDTH-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= fits ? (rem_sh - {1'b0, r_div}) : rem_sh;
                r_quot <= {r_quot[WIDTH-2:0], fits};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> sv/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: sequencer, binary gcd and output register.
// Depends on rau_pkg, rau_mul and rau_div.
//
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | operation, a_num, a_den, b_num, b_den | -
//  m_axis   | out       | res_num, res_den               | status
//
// Each item runs through the three products, the sum, the binary gcd loop (one
// shift or subtract a cycle) and two divisions by the gcd, numerator first.
// Zero-denominator errors go from idle straight to the final step. Ready is
// high only while idle. A finished item sits in the output register; a stalled
// output holds the sequencer at its last step. Reset is synchronous and clears
// control state.
module rational_arithmetic_unit #(
    parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // operation[1:0], a_num[33:2], a_den[65:34], b_num[97:66], b_den[129:98]
    input  logic [rau_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // res_num[31:0], res_den[62:32]
    output logic [rau_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]                         o_m_axis_tuser
);

    localparam int W  = VALUE_BITS;
    localparam int PW = 2 * VALUE_BITS;
    localparam int KW = $clog2(PW + 1);
    localparam int FB = rau_pkg::FIELD_BITS;
    localparam int DB = rau_pkg::DEN_BITS;
    localparam logic [PW-1:0] LIM = {{(PW-1){1'b0}}, 1'b1} << (W - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_GCD, S_DIVN, S_DIVD, S_CHK, S_FIN
    } t_state;

    t_state             r_state, n_state;
    rau_pkg::t_op       r_op, n_op;
    logic [W-1:0]       r_an, r_ad, r_bn, r_bd;
    logic [W-1:0]       n_an, n_ad, n_bn, n_bd;
    logic [3:0]         r_sg, n_sg;        // signs: an, ad, bn, bd
    logic [1:0]         r_cnt, n_cnt;
    logic [PW-1:0]      r_p1, r_p2, r_den, n_p1, n_p2, n_den;
    logic               r_s1, r_s2, r_dneg, n_s1, n_s2, n_dneg;
    logic [PW-1:0]      r_nmag, n_nmag;
    logic               r_nneg, n_nneg;
    logic [PW-1:0]      r_x, r_y, n_x, n_y;
    logic [KW-1:0]      r_k, n_k;
    logic [PW-1:0]      r_g, n_g;
    logic [PW-1:0]      r_nq, r_dq, n_nq, n_dq;
    logic [W-1:0]       r_res_num, n_res_num;
    logic [W-2:0]       r_res_den, n_res_den;
    rau_pkg::t_status   r_res_st, n_res_st;
    logic               r_ovalid, n_ovalid;
    logic [FB-1:0]      r_onum, n_onum;
    logic [DB-1:0]      r_oden, n_oden;
    rau_pkg::t_status   r_ost, n_ost;

    // Operand fields, low VALUE_BITS bits of each
    logic [W-1:0] f_an, f_ad, f_bn, f_bd;
    assign f_an = i_s_axis_tdata[2 +: W];
    assign f_ad = i_s_axis_tdata[34 +: W];
    assign f_bn = i_s_axis_tdata[66 +: W];
    assign f_bd = i_s_axis_tdata[98 +: W];

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // Shared multiplier operand select per product slot
    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] prod;

    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        unique case (r_cnt)
            2'd0: begin
                if (r_op == rau_pkg::OP_MUL) begin
                    mul_b = r_bn;
                end
            end
            2'd1: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            default: begin
                if (r_op == rau_pkg::OP_DIV) begin
                    mul_a = r_bn;
                    mul_b = r_ad;
                end else begin
                    mul_a = r_ad;
                    mul_b = r_bd;
                end
            end
        endcase
    end

    rau_mul #(.WIDTH(W)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Divider shared by numerator and denominator reduction
    logic          div_start, div_done;
    logic [PW-1:0] div_dividend, div_divisor, div_quot, g_now;
    logic          gcd_end;

    assign g_now        = r_y << r_k;
    assign gcd_end      = (r_state == S_GCD) && (r_x == '0) && (r_nmag != '0);
    assign div_start    = gcd_end || ((r_state == S_DIVN) && div_done);
    assign div_dividend = (r_state == S_GCD) ? r_nmag : r_den;
    assign div_divisor  = (r_state == S_GCD) ? g_now : r_g;

    rau_div #(.WIDTH(PW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Sum of cross products, signs of zero products dropped
    logic e1, e2;
    assign e1 = r_s1 && (r_p1 != '0);
    assign e2 = (r_s2 && (r_p2 != '0)) ^ ((r_op == rau_pkg::OP_SUB) && (r_p2 != '0));

    logic rneg;
    assign rneg = r_nneg ^ r_dneg;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_an      = r_an;
        n_ad      = r_ad;
        n_bn      = r_bn;
        n_bd      = r_bd;
        n_sg      = r_sg;
        n_cnt     = r_cnt;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_den     = r_den;
        n_s1      = r_s1;
        n_s2      = r_s2;
        n_dneg    = r_dneg;
        n_nmag    = r_nmag;
        n_nneg    = r_nneg;
        n_x       = r_x;
        n_y       = r_y;
        n_k       = r_k;
        n_g       = r_g;
        n_nq      = r_nq;
        n_dq      = r_dq;
        n_res_num = r_res_num;
        n_res_den = r_res_den;
        n_res_st  = r_res_st;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_onum    = r_onum;
        n_oden    = r_oden;
        n_ost     = r_ost;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op  = rau_pkg::t_op'(i_s_axis_tdata[1:0]);
                    n_an  = mag(f_an);
                    n_ad  = mag(f_ad);
                    n_bn  = mag(f_bn);
                    n_bd  = mag(f_bd);
                    n_sg  = {f_bd[W-1], f_bn[W-1], f_ad[W-1], f_an[W-1]};
                    n_cnt = '0;
                    if (f_ad == '0 || f_bd == '0 ||
                        (i_s_axis_tdata[1:0] == rau_pkg::OP_DIV && f_bn == '0)) begin
                        n_res_num = '0;
                        n_res_den = '0;
                        n_res_st  = rau_pkg::ST_ZERO_DEN;
                        n_state   = S_FIN;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_cnt = r_cnt + 1'b1;
                unique case (r_cnt)
                    2'd1: begin
                        n_p1 = prod;
                        n_s1 = r_sg[0] ^ ((r_op == rau_pkg::OP_MUL) ? r_sg[2] : r_sg[3]);
                    end
                    2'd2: begin
                        n_p2 = prod;
                        n_s2 = r_sg[2] ^ r_sg[1];
                    end
                    2'd3: begin
                        n_den   = prod;
                        n_dneg  = (r_op == rau_pkg::OP_DIV) ? (r_sg[2] ^ r_sg[1])
                                                            : (r_sg[1] ^ r_sg[3]);
                        n_state = S_SUM;
                    end
                    default: begin
                    end
                endcase
                // keep the slot select aligned with the issued pair
                if (r_cnt == 2'd2) n_cnt = 2'd3;
            end
            S_SUM: begin
                if (r_op == rau_pkg::OP_ADD || r_op == rau_pkg::OP_SUB) begin
                    if (e1 == e2) begin
                        n_nmag = r_p1 + r_p2;
                        n_nneg = e1;
                    end else if (r_p1 >= r_p2) begin
                        n_nmag = r_p1 - r_p2;
                        n_nneg = e1;
                    end else begin
                        n_nmag = r_p2 - r_p1;
                        n_nneg = e2;
                    end
                end else begin
                    n_nmag = r_p1;
                    n_nneg = e1;
                end
                n_x     = n_nmag;
                n_y     = r_den;
                n_k     = '0;
                n_state = S_GCD;
            end
            S_GCD: begin
                // Binary gcd, one shift or subtract a cycle
                if (r_x == '0) begin
                    if (r_nmag == '0) begin
                        n_res_num = '0;
                        n_res_den = (W-1)'(1);
                        n_res_st  = rau_pkg::ST_OK;
                        n_state   = S_FIN;
                    end else begin
                        n_g     = g_now;
                        n_state = S_DIVN;
                    end
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x >= r_y) begin
                    n_x = r_x - r_y;
                end else begin
                    n_y = r_y - r_x;
                end
            end
            S_DIVN: begin
                if (div_done) begin
                    n_nq    = div_quot;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                if (div_done) begin
                    n_dq    = div_quot;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // Range check of the reduced value
                if (r_dq > LIM - 1'b1 || (rneg ? (r_nq > LIM) : (r_nq > LIM - 1'b1))) begin
                    n_res_num = '0;
                    n_res_den = '0;
                    n_res_st  = rau_pkg::ST_OVERFLOW;
                end else begin
                    n_res_num = rneg ? (~r_nq[W-1:0] + 1'b1) : r_nq[W-1:0];
                    n_res_den = r_dq[W-2:0];
                    n_res_st  = rau_pkg::ST_OK;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_onum   = FB'($signed(r_res_num));
                    n_oden   = DB'(r_res_den);
                    n_ost    = r_res_st;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
        end
        r_op      <= n_op;
        r_an      <= n_an;
        r_ad      <= n_ad;
        r_bn      <= n_bn;
        r_bd      <= n_bd;
        r_sg      <= n_sg;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_den     <= n_den;
        r_s1      <= n_s1;
        r_s2      <= n_s2;
        r_dneg    <= n_dneg;
        r_nmag    <= n_nmag;
        r_nneg    <= n_nneg;
        r_x       <= n_x;
        r_y       <= n_y;
        r_k       <= n_k;
        r_g       <= n_g;
        r_nq      <= n_nq;
        r_dq      <= n_dq;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_res_st  <= n_res_st;
        r_onum    <= n_onum;
        r_oden    <= n_oden;
        r_ost     <= n_ost;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_oden, r_onum};
    assign o_m_axis_tuser  = r_ost;

endmodule

>>> dv/rational_arithmetic_unit_tb.sv
// Testbench for the rational arithmetic unit: predicts each reduced result with an
// exact 64-bit cross-product and Euclidean gcd, and checks every output item in order.
// Depends on rau_pkg and rational_arithmetic_unit.
module rational_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 800;

    typedef struct packed {
        logic [31:0]      num;
        logic [30:0]      den;
        rau_pkg::t_status status;
    } t_ratio_res;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_s_axis_tvalid;
    logic                              o_s_axis_tready;
    logic [rau_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready;
    logic [rau_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic [1:0]                        o_m_axis_tuser;

    t_ratio_res expected_q[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         recv_hold;
    int         mismatches;
    int         results_seen;
    int         items_sent;
    int         quiet_cycles;

    rational_arithmetic_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Magnitude of a signed 64-bit value, held in 64 bits
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Exact rational result in lowest terms
    function automatic t_ratio_res reduce_ratio(input rau_pkg::t_op op,
                                                input logic signed [31:0] an,
                                                input logic signed [31:0] ad,
                                                input logic signed [31:0] bn,
                                                input logic signed [31:0] bd);
        t_ratio_res r;
        logic signed [63:0] p1, p2, d;
        logic [63:0] m1, m2, nm, dm, x, y, t;
        logic n1, n2, nneg, dneg;
        r = '{num: '0, den: '0, status: rau_pkg::ST_OK};
        if (ad == 0 || bd == 0 || (op == rau_pkg::OP_DIV && bn == 0)) begin
            r.status = rau_pkg::ST_ZERO_DEN;
            return r;
        end
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                p1 = 64'(an) * 64'(bd);
                p2 = 64'(bn) * 64'(ad);
                d  = 64'(ad) * 64'(bd);
                n1 = p1 < 0;
                n2 = p2 < 0;
                if (op == rau_pkg::OP_SUB && p2 != 0) n2 = !n2;
                m1 = mag64(p1);
                m2 = mag64(p2);
                if (n1 == n2) begin
                    nneg = n1; nm = m1 + m2;
                end else if (m1 >= m2) begin
                    nneg = n1; nm = m1 - m2;
                end else begin
                    nneg = n2; nm = m2 - m1;
                end
            end
            rau_pkg::OP_MUL: begin
                p1 = 64'(an) * 64'(bn);
                d  = 64'(ad) * 64'(bd);
                nneg = p1 < 0; nm = mag64(p1);
            end
            default: begin
                p1 = 64'(an) * 64'(bd);
                d  = 64'(bn) * 64'(ad);
                nneg = p1 < 0; nm = mag64(p1);
            end
        endcase
        dneg = d < 0;
        dm = mag64(d);
        x = nm;
        y = dm;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        if (x != 0) begin
            nm = nm / x;
            dm = dm / x;
        end
        if (nm == 0) begin
            nneg = 1'b0;
            dm = 1;
        end else if (dneg) begin
            nneg = !nneg;
        end
        if (dm > 64'h7FFF_FFFF || (nneg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF)) begin
            r.status = rau_pkg::ST_OVERFLOW;
            return r;
        end
        r.num = nneg ? 32'(-nm) : nm[31:0];
        r.den = dm[30:0];
        return r;
    endfunction

    // Offer one item, record its expected result once accepted; valid stays up
    // so that the next item can follow at once
    task automatic send_ratio(input rau_pkg::t_op op, input logic [31:0] an,
                              input logic [31:0] ad, input logic [31:0] bn,
                              input logic [31:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, bd, bn, ad, an, op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_q.push_back(reduce_ratio(op, an, ad, bn, bd));
        items_sent++;
    endtask

    // Sender pauses until every expected result has come
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'($urandom_range(16)) - 32'd8;
            1: return 32'($urandom_range(2000)) - 32'd1000;
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return 32'($urandom_range(65535)) << $urandom_range(16);
            default: return $urandom();
        endcase
    endfunction

    // Directed: extremes, every operation, error and overflow cases
    task automatic test_directed();
        rau_pkg::t_op op;
        for (int k = 0; k < 4; k++) begin
            op = rau_pkg::t_op'(k);
            send_ratio(op, 32'd1, 32'd2, 32'd1, 32'd3);
            send_ratio(op, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
            send_ratio(op, 32'd5, 32'd0, 32'd1, 32'd1);
            send_ratio(op, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
        end
        send_ratio(rau_pkg::OP_DIV, 32'd3, 32'd4, 32'd0, 32'd7);
        send_ratio(rau_pkg::OP_ADD, 32'd1, 32'd1, 32'd0, 32'd0);
        send_ratio(rau_pkg::OP_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
        send_ratio(rau_pkg::OP_MUL, 32'd0, 32'hFFFF_FFF9, 32'd5, 32'd3);
        send_ratio(rau_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        send_ratio(rau_pkg::OP_DIV, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFC);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_ratio(rau_pkg::t_op'($urandom_range(3)), rand_operand(), rand_operand(),
                       rand_operand(), rand_operand());
        end
    endtask

    // Long receiver stall while the sender keeps offering items
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (3000) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            test_random(8);
        join
        wait_drained();
    endtask

    // Sink side: ready and result checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                t_ratio_res want;
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item %h", o_m_axis_tdata);
                end else begin
                    want = expected_q.pop_front();
                    if (o_m_axis_tdata[31:0] !== want.num || o_m_axis_tdata[62:32] !== want.den
                        || o_m_axis_tuser !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp num %h den %h st %0d, got num %h den %h st %0d",
                                     want.num, want.den, want.status, o_m_axis_tdata[31:0],
                                     o_m_axis_tdata[62:32], o_m_axis_tuser);
                    end
                end
            end
            i_m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 1'b0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 30; recv_idle_pct = 79;
        test_random(540);
        wait_drained();
        send_idle_pct = 79; recv_idle_pct = 30;
        test_random(540);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(540);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items over all four operations, %0d results checked.",
                 items_sent, results_seen);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d left over", mismatches, expected_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
